// ===== hdl/plip_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// plip_pkg
// Shared types and constants of the piecewise linear interpolator: field
// widths, table size, serial arithmetic step counts and operation codes.
// ============================================================================
package plip_pkg;

    // Field widths of the Q16.16 values and of the configuration register.
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    // Breakpoint table size.
    localparam int MAX_POINTS = 64;
    localparam int PTR_W      = $clog2(MAX_POINTS);

    // Serial multiply and divide sizes: differences are one bit wider than
    // the data, the product twice that, and the quotient is kept to 40 bits.
    localparam int EXT_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * EXT_W;
    localparam int QUOT_W    = 40;
    localparam int MUL_STEPS = EXT_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Width of the final sum before saturation.
    localparam int SUM_W = QUOT_W + 2;

    // Operation codes of an input item.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Step controls from the sequencer to the serial arithmetic unit.
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
    } t_arith_ctl;

endpackage

// ===== hdl/piecewise_linear_interpolator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// piecewise_linear_interpolator
// Piecewise linear interpolation over a loaded breakpoint table, Q16.16,
// with extrapolation, saturation and zero-width segment flags.
// ============================================================================
// Query sequence: a linear scan reads breakpoints until one lies at or above
// the query x (at most the clamped breakpoint count), the fetch reads both
// ends of the chosen segment, then a serial multiply and a serial divide form
// the offset; a zero-width segment skips both. A load gives no result; busy
// drops in the strobe cycle, one item at a time.
// Reset (synchronous, active low) sets point_count to 2; the table is undefined.
module piecewise_linear_interpolator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [plip_pkg::PTR_W-1:0]      i_point_index,
    input  logic signed [plip_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [plip_pkg::DATA_W-1:0] i_y_value,
    input  logic                            i_last_query,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [plip_pkg::COUNT_W-1:0]    i_cfg_data,
    output logic                            o_result_strobe,
    output logic signed [plip_pkg::DATA_W-1:0] o_y_result,
    output logic                            o_extrapolated,
    output logic                            o_saturated,
    output logic                            o_zero_width,
    output logic                            o_last_result
);
    import plip_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FETCH0 = 3'd2;
    localparam logic [2:0] ST_FETCH1 = 3'd3;
    localparam logic [2:0] ST_FETCH2 = 3'd4;
    localparam logic [2:0] ST_SETUP  = 3'd5;
    localparam logic [2:0] ST_MUL    = 3'd6;
    localparam logic [2:0] ST_DIV    = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [PTR_W-1:0]   r_k, n_k;
    logic [PTR_W-1:0]   r_s, n_s;
    logic               r_extra, n_extra;
    logic               r_last;
    logic [DATA_W-1:0]  r_xq;
    logic [DATA_W-1:0]  r_x0, r_x1, r_y0, r_y1;
    logic               r_neg;
    logic               r_zw;
    logic               r_final;
    logic [STEP_W-1:0]  r_cnt;
    logic [COUNT_W-1:0] r_point_count;

    logic               accept;
    logic               cfg_xfer;
    logic [COUNT_W-1:0] n_used;
    logic [PTR_W-1:0]   n_m1;
    logic [PTR_W-1:0]   rd_addr;
    logic [DATA_W-1:0]  rd_x, rd_y;
    logic               scan_ge;
    t_arith_ctl         arith_ctl;
    logic [QUOT_W-1:0]  quot;
    logic               big;

    logic [EXT_W-1:0]   w_diff, dx_diff, dy_diff;
    logic [EXT_W-1:0]   w_mag, dx_mag, dy_mag;

    logic               neg_eff;
    logic [SUM_W-1:0]   y_sum;
    logic               sat_hi, sat_lo;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE) || r_final;
    assign o_cfg_ready = !busy;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= COUNT_W'(2);
        end else if (cfg_xfer) begin
            r_point_count <= i_cfg_data;
        end
    end

    // Breakpoint count in use, clamped to the range 2 to the table size.
    always_comb begin
        if (r_point_count < COUNT_W'(2)) begin
            n_used = COUNT_W'(2);
        end else if (r_point_count > COUNT_W'(MAX_POINTS)) begin
            n_used = COUNT_W'(MAX_POINTS);
        end else begin
            n_used = r_point_count;
        end
    end
    assign n_m1 = PTR_W'(n_used - COUNT_W'(1));

    // Table read address: entry 0 is prefetched while idle, the scan reads
    // one entry ahead, and the fetch reads both ends of the chosen segment.
    always_comb begin
        unique case (r_state)
            ST_IDLE:   rd_addr = '0;
            ST_SCAN:   rd_addr = r_k + PTR_W'(1);
            ST_FETCH0: rd_addr = r_s;
            ST_FETCH1: rd_addr = r_s + PTR_W'(1);
            default:   rd_addr = r_s;
        endcase
    end

    plip_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_operation == OP_LOAD)),
        .i_wr_addr (i_point_index),
        .i_wr_x    (i_x_value),
        .i_wr_y    (i_y_value),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    // Scan compare: first breakpoint at or above the query x.
    assign scan_ge = $signed(rd_x) >= $signed(r_xq);

    // Segment differences and their magnitudes.
    assign w_diff  = {r_x1[DATA_W-1], r_x1} - {r_x0[DATA_W-1], r_x0};
    assign dx_diff = {r_xq[DATA_W-1], r_xq} - {r_x0[DATA_W-1], r_x0};
    assign dy_diff = {r_y1[DATA_W-1], r_y1} - {r_y0[DATA_W-1], r_y0};
    assign w_mag   = w_diff[EXT_W-1]  ? -w_diff  : w_diff;
    assign dx_mag  = dx_diff[EXT_W-1] ? -dx_diff : dx_diff;
    assign dy_mag  = dy_diff[EXT_W-1] ? -dy_diff : dy_diff;

    // Arithmetic step controls.
    always_comb begin
        arith_ctl.load     = (r_state == ST_SETUP);
        arith_ctl.mul_step = (r_state == ST_MUL);
        arith_ctl.div_step = (r_state == ST_DIV);
    end

    plip_arith u_arith (
        .i_clk     (i_clk),
        .i_ctl     (arith_ctl),
        .i_mcand   (dx_mag),
        .i_mplier  (dy_mag),
        .i_divisor (w_mag),
        .o_quot    (quot),
        .o_big     (big)
    );

    // Sequencer next state and scan decision.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_s     = r_s;
        n_extra = r_extra;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_operation == OP_QUERY)) begin
                    n_state = ST_SCAN;
                    n_k     = '0;
                end
            end
            ST_SCAN: begin
                if (scan_ge) begin
                    n_state = ST_FETCH0;
                    if (r_k == '0) begin
                        n_s     = '0;
                        n_extra = (rd_x != r_xq);
                    end else begin
                        n_s     = r_k - PTR_W'(1);
                        n_extra = 1'b0;
                    end
                end else if (r_k == n_m1) begin
                    // Query lies above every breakpoint in use.
                    n_state = ST_FETCH0;
                    n_s     = n_m1 - PTR_W'(1);
                    n_extra = 1'b1;
                end else begin
                    n_k = r_k + PTR_W'(1);
                end
            end
            ST_FETCH0: n_state = ST_FETCH1;
            ST_FETCH1: n_state = ST_FETCH2;
            ST_FETCH2: n_state = ST_SETUP;
            ST_SETUP: begin
                n_state = (w_diff == '0) ? ST_IDLE : ST_MUL;
            end
            ST_MUL: begin
                if (r_cnt == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_final <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            // Result is formed in the cycle after the divide or a zero-width setup.
            r_final <= ((r_state == ST_SETUP) && (w_diff == '0)) ||
                       ((r_state == ST_DIV) && (r_cnt == STEP_W'(DIV_STEPS - 1)));
            if ((r_state == ST_MUL) && (r_cnt != STEP_W'(MUL_STEPS - 1))) begin
                r_cnt <= r_cnt + STEP_W'(1);
            end else if ((r_state == ST_DIV) && (r_cnt != STEP_W'(DIV_STEPS - 1))) begin
                r_cnt <= r_cnt + STEP_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Query payload registers.
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_s     <= n_s;
        r_extra <= n_extra;
        if (accept) begin
            r_xq   <= i_x_value;
            r_last <= i_last_query;
        end
        if (r_state == ST_FETCH1) begin
            r_x0 <= rd_x;
            r_y0 <= rd_y;
        end
        if (r_state == ST_FETCH2) begin
            r_x1 <= rd_x;
            r_y1 <= rd_y;
        end
        if (r_state == ST_SETUP) begin
            r_zw  <= (w_diff == '0);
            r_neg <= (dx_diff[EXT_W-1] ^ dy_diff[EXT_W-1]) ^ w_diff[EXT_W-1];
        end
    end

    // Final add of the quotient to y0 and saturation.
    assign neg_eff = r_neg && (quot != '0);
    assign y_sum   = neg_eff ? ({{(SUM_W-DATA_W){r_y0[DATA_W-1]}}, r_y0} - {2'b00, quot})
                             : ({{(SUM_W-DATA_W){r_y0[DATA_W-1]}}, r_y0} + {2'b00, quot});
    assign sat_hi  = !y_sum[SUM_W-1] && (|y_sum[SUM_W-2:DATA_W-1]);
    assign sat_lo  = y_sum[SUM_W-1] && !(&y_sum[SUM_W-2:DATA_W-1]);

    // Result strobe, one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= r_final;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (r_final) begin
            o_extrapolated <= r_extra;
            o_zero_width   <= r_zw;
            o_last_result  <= r_last;
            if (r_zw) begin
                o_y_result  <= '0;
                o_saturated <= 1'b0;
            end else if (big) begin
                o_y_result  <= neg_eff ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
                o_saturated <= 1'b1;
            end else if (sat_hi) begin
                o_y_result  <= {1'b0, {(DATA_W-1){1'b1}}};
                o_saturated <= 1'b1;
            end else if (sat_lo) begin
                o_y_result  <= {1'b1, {(DATA_W-1){1'b0}}};
                o_saturated <= 1'b1;
            end else begin
                o_y_result  <= y_sum[DATA_W-1:0];
                o_saturated <= 1'b0;
            end
        end
    end

    // Assertions.
    a_strobe_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_final))
        else $error("result strobe without a finished query");

    a_zero_width_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_zero_width) |-> ((o_y_result == '0) && !o_saturated))
        else $error("zero-width segment gave a nonzero or saturated result");

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == OP_QUERY)) |=> busy)
        else $error("accepted query did not make the block busy");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_k <= n_m1))
        else $error("scan index beyond breakpoints in use");

endmodule

// ===== hdl/plip_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// plip_table
// Breakpoint storage: one x memory and one y memory sharing a write port
// for load items and a single registered read port.
// ============================================================================
module plip_table (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [plip_pkg::PTR_W-1:0]    i_wr_addr,
    input  logic [plip_pkg::DATA_W-1:0]   i_wr_x,
    input  logic [plip_pkg::DATA_W-1:0]   i_wr_y,
    input  logic [plip_pkg::PTR_W-1:0]    i_rd_addr,
    output logic [plip_pkg::DATA_W-1:0]   o_rd_x,
    output logic [plip_pkg::DATA_W-1:0]   o_rd_y
);
    import plip_pkg::*;

    logic [DATA_W-1:0] r_mem_x [MAX_POINTS];
    logic [DATA_W-1:0] r_mem_y [MAX_POINTS];

    // Write one breakpoint pair per load transfer.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_x[i_wr_addr] <= i_wr_x;
            r_mem_y[i_wr_addr] <= i_wr_y;
        end
    end

    // Registered read: data appears the cycle after the address.
    always_ff @(posedge i_clk) begin
        o_rd_x <= r_mem_x[i_rd_addr];
        o_rd_y <= r_mem_y[i_rd_addr];
    end

endmodule

// ===== hdl/plip_arith.sv =====
`timescale 1ns / 1ps
// ============================================================================
// plip_arith
// Bit-serial arithmetic: a shift-add multiplier of two 33-bit magnitudes
// followed by a restoring divider, one bit per cycle, sharing one register.
// ============================================================================
module plip_arith (
    input  logic                          i_clk,
    input  plip_pkg::t_arith_ctl          i_ctl,
    input  logic [plip_pkg::EXT_W-1:0]    i_mcand,
    input  logic [plip_pkg::EXT_W-1:0]    i_mplier,
    input  logic [plip_pkg::EXT_W-1:0]    i_divisor,
    output logic [plip_pkg::QUOT_W-1:0]   o_quot,
    output logic                          o_big
);
    import plip_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [EXT_W-1:0]  r_mcand;
    logic [EXT_W-1:0]  r_div;
    logic [EXT_W-1:0]  r_rem;

    logic [EXT_W:0]    mul_sum;
    logic [EXT_W:0]    rem_sh;
    logic              rem_ge;
    logic [EXT_W:0]    rem_diff;

    // Multiply step: add the multiplicand to the upper half when the low
    // multiplier bit is set, then shift right.
    assign mul_sum = {1'b0, r_prod[PROD_W-1:EXT_W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);

    // Divide step: bring in the next dividend bit and subtract if it fits.
    assign rem_sh   = {r_rem, r_prod[PROD_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign rem_diff = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod  <= {{EXT_W{1'b0}}, i_mplier};
            r_mcand <= i_mcand;
            r_div   <= i_divisor;
            r_rem   <= '0;
        end else if (i_ctl.mul_step) begin
            r_prod <= {mul_sum, r_prod[EXT_W-1:1]};
        end else if (i_ctl.div_step) begin
            // Quotient bits enter at the bottom as dividend bits leave the top.
            r_prod <= {r_prod[PROD_W-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_diff[EXT_W-1:0] : rem_sh[EXT_W-1:0];
        end
    end

    // After the divide the register holds the whole quotient.
    assign o_quot = r_prod[QUOT_W-1:0];
    assign o_big  = |r_prod[PROD_W-1:QUOT_W];

endmodule

// ===== verif/piecewise_linear_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// piecewise_linear_interpolator_tb
// Self-checking bench for the piecewise linear interpolator. A driver feeds
// load and query commands from a queue and a monitor predicts every query
// result from its own copy of the breakpoint table and point count. A short
// directed run covers edge values, extrapolation, saturation, zero-width and
// unsorted segments; random phases then reload sorted tables at several
// point counts, including the out-of-range counts, and query them.
// ============================================================================
module piecewise_linear_interpolator_tb;

    import plip_pkg::*;

    localparam int ITEM_TARGET       = 1100;
    localparam int RESET_CYCLES      = 11;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int LOAD_SETTLE       = 4;
    localparam int END_DRAIN_CYCLES  = 200;
    localparam int MAX_REPORTS       = 10;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

    // One command as presented on the input ports.
    typedef struct packed {
        logic                     op;
        logic [PTR_W-1:0]         index;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic                     last_flag;
    } t_plip_item;

    // One interpolation result as seen on the output ports.
    typedef struct packed {
        logic signed [DATA_W-1:0] y;
        logic                     extrapolated;
        logic                     saturated;
        logic                     zero_width;
        logic                     last_flag;
    } t_plip_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_operation;
    logic [PTR_W-1:0]         i_point_index;
    logic signed [DATA_W-1:0] i_x_value;
    logic signed [DATA_W-1:0] i_y_value;
    logic                     i_last_query;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [COUNT_W-1:0]       i_cfg_data;
    logic                     o_result_strobe;
    logic signed [DATA_W-1:0] o_y_result;
    logic                     o_extrapolated;
    logic                     o_saturated;
    logic                     o_zero_width;
    logic                     o_last_result;

    piecewise_linear_interpolator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_point_index   (i_point_index),
        .i_x_value       (i_x_value),
        .i_y_value       (i_y_value),
        .i_last_query    (i_last_query),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_y_result      (o_y_result),
        .o_extrapolated  (o_extrapolated),
        .o_saturated     (o_saturated),
        .o_zero_width    (o_zero_width),
        .o_last_result   (o_last_result)
    );

    // Commands waiting for the driver and results waiting for the block.
    t_plip_item   pending_commands[$];
    t_plip_result pending_results[$];

    // Predicted block state: breakpoint table and point count.
    logic signed [DATA_W-1:0] breakpoint_x[MAX_POINTS];
    logic signed [DATA_W-1:0] breakpoint_y[MAX_POINTS];
    logic [COUNT_W-1:0]       point_count_model;

    int  issued_count;
    int  accepted_count;
    int  command_total;
    int  failure_count;
    int  idle_cycles;
    bit  steady_feed;

    // Stimulus-side copy of the sorted table of the current phase.
    longint gen_x[MAX_POINTS];

    always #10 i_clk = ~i_clk;

    // Counts a failure and prints the first few of them.
    task automatic note_failure(string msg);
        failure_count++;
        if (failure_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Expected result of a query at xq against the predicted table.
    function automatic t_plip_result interpolate_query(logic signed [DATA_W-1:0] xq,
                                                       logic last_flag);
        t_plip_result res;
        int           n;
        int           k;
        int           seg;
        longint       x0, x1, y0, y1, dx, dy, w, yv;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quot;
        logic [QUOT_W-1:0] q;
        logic         neg;
        res = '0;
        res.last_flag = last_flag;
        n = int'(point_count_model);
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;

        // Segment choice: first breakpoint at or above xq.
        k = 0;
        while (k < n && breakpoint_x[k] < xq) k++;
        if (k == 0) begin
            seg = 0;
            res.extrapolated = (xq < breakpoint_x[0]);
        end else if (k == n) begin
            seg = n - 2;
            res.extrapolated = 1'b1;
        end else begin
            seg = k - 1;
        end

        x0 = longint'(breakpoint_x[seg]);
        x1 = longint'(breakpoint_x[seg + 1]);
        y0 = longint'(breakpoint_y[seg]);
        y1 = longint'(breakpoint_y[seg + 1]);
        w  = x1 - x0;
        if (w == 0) begin
            res.zero_width = 1'b1;
            return res;
        end

        // Sign and magnitude form: exact product, truncated quotient.
        dx   = longint'(xq) - x0;
        dy   = y1 - y0;
        neg  = ((dx < 0) != (dy < 0)) != (w < 0);
        prod = PROD_W'(dx < 0 ? -dx : dx) * PROD_W'(dy < 0 ? -dy : dy);
        quot = prod / PROD_W'(w < 0 ? -w : w);
        q    = quot[QUOT_W-1:0];
        if (q == '0) neg = 1'b0;
        if (|quot[PROD_W-1:QUOT_W]) begin
            res.saturated = 1'b1;
            res.y = neg ? Q_MIN : Q_MAX;
        end else begin
            yv = neg ? y0 - longint'(q) : y0 + longint'(q);
            if (yv > longint'(Q_MAX)) begin
                yv = longint'(Q_MAX);
                res.saturated = 1'b1;
            end
            if (yv < longint'(Q_MIN)) begin
                yv = longint'(Q_MIN);
                res.saturated = 1'b1;
            end
            res.y = DATA_W'(yv);
        end
        return res;
    endfunction

    // Driver: presents the next command, holding it until the transfer.
    always @(negedge i_clk) begin
        t_plip_item cmd;
        if (i_rst_n && !(start && accepted_count != issued_count)) begin
            if (pending_commands.size() != 0 &&
                (steady_feed || $urandom_range(0, 99) >= 25)) begin
                cmd           = pending_commands.pop_front();
                i_operation   <= cmd.op;
                i_point_index <= cmd.index;
                i_x_value     <= cmd.x;
                i_y_value     <= cmd.y;
                i_last_query  <= cmd.last_flag;
                start         <= 1'b1;
                issued_count++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results, then tracks each command transfer.
    always @(posedge i_clk) begin
        t_plip_result got;
        t_plip_result want;
        if (i_rst_n) begin
            if (o_result_strobe) begin
                got = {o_y_result, o_extrapolated, o_saturated, o_zero_width, o_last_result};
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result y=%h ext=%b sat=%b zw=%b last=%b",
                                           got.y, got.extrapolated, got.saturated,
                                           got.zero_width, got.last_flag));
                end else begin
                    want = pending_results.pop_front();
                    if (got.y !== want.y || got.extrapolated !== want.extrapolated ||
                        got.saturated !== want.saturated ||
                        got.zero_width !== want.zero_width ||
                        got.last_flag !== want.last_flag) begin
                        note_failure($sformatf(
                            "result mismatch: expected y=%h ext=%b sat=%b zw=%b last=%b, got y=%h ext=%b sat=%b zw=%b last=%b",
                            want.y, want.extrapolated, want.saturated, want.zero_width,
                            want.last_flag, got.y, got.extrapolated, got.saturated,
                            got.zero_width, got.last_flag));
                    end
                end
            end
            if (start && !busy) begin
                accepted_count++;
                if (i_operation == OP_LOAD) begin
                    breakpoint_x[i_point_index] = i_x_value;
                    breakpoint_y[i_point_index] = i_y_value;
                end else begin
                    pending_results.push_back(interpolate_query(i_x_value, i_last_query));
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** piecewise_linear_interpolator: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_command(logic op, int index, logic signed [DATA_W-1:0] x,
                                 logic signed [DATA_W-1:0] y, logic last_flag);
        t_plip_item cmd;
        cmd.op        = op;
        cmd.index     = PTR_W'(index);
        cmd.x         = x;
        cmd.y         = y;
        cmd.last_flag = last_flag;
        pending_commands.push_back(cmd);
        command_total++;
    endtask

    // Waits until every command is taken, every result is in and the block
    // has finished any trailing load.
    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (pending_commands.size() != 0 || accepted_count != issued_count ||
               pending_results.size() != 0);
        repeat (LOAD_SETTLE) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    // One transfer on the configuration channel; called at a falling edge.
    task automatic write_point_count(logic [COUNT_W-1:0] value);
        repeat ($urandom_range(0, 3)) @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        point_count_model = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads entries 0..n-1 with ascending x; some steps are zero.
    task automatic load_sorted_table(int n);
        longint step_max;
        longint span;
        longint step;
        bit     wide_y;
        logic signed [DATA_W-1:0] yv;
        case ($urandom_range(0, 4))
            0:       step_max = 2;
            1:       step_max = 'h100;
            2:       step_max = 'h1_0000;
            3:       step_max = 'h100_0000;
            default: step_max = 64'hFFFF_FFFF / (n - 1);
        endcase
        span     = step_max * (n - 1);
        gen_x[0] = -64'sd2147483648 + (longint'($urandom) % (64'sh1_0000_0000 - span));
        wide_y   = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                step = ($urandom_range(0, 9) == 0) ? 0 :
                       longint'($urandom_range(1, 32'(step_max)));
                gen_x[i] = gen_x[i-1] + step;
            end
            yv = wide_y ? $signed($urandom) : $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
            queue_command(OP_LOAD, i, DATA_W'(gen_x[i]), yv, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int     n;
        int     phase;
        int     queries;
        int     seg;
        int     pick;
        longint lo;
        longint hi;
        logic signed [DATA_W-1:0] xq;
        logic [COUNT_W-1:0] counts[7];

        counts = '{7'd0, 7'd64, 7'd1, 7'd127, 7'd65, 7'd2, 7'd3};
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = OP_LOAD;
        i_point_index  = '0;
        i_x_value      = '0;
        i_y_value      = '0;
        i_last_query   = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        issued_count   = 0;
        accepted_count = 0;
        command_total  = 0;
        failure_count  = 0;
        idle_cycles    = 0;
        steady_feed    = 1'b0;
        point_count_model = 7'd2;
        foreach (breakpoint_x[i]) begin
            breakpoint_x[i] = '0;
            breakpoint_y[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: two points at the reset count of two.
        queue_command(OP_LOAD, 0, -Q_ONE, 32'sh0, 1'b0);
        queue_command(OP_LOAD, 1, Q_ONE, 32'sh2_0000, 1'b0);
        queue_command(OP_QUERY, 0, 32'sh0, 32'sh0, 1'b0);
        queue_command(OP_QUERY, 0, -Q_ONE, Q_MAX, 1'b1);
        queue_command(OP_QUERY, 0, Q_ONE, Q_MIN, 1'b0);
        queue_command(OP_QUERY, 0, -32'sh2_0000, 32'sh0, 1'b1);
        queue_command(OP_QUERY, 0, 32'sh3_0000, 32'sh0, 1'b0);
        queue_command(OP_QUERY, 0, Q_MIN, 32'sh0, 1'b0);
        queue_command(OP_QUERY, 0, Q_MAX, 32'sh0, 1'b1);
        // Full-scale y swing between the two points.
        queue_command(OP_LOAD, 0, -Q_ONE, Q_MIN, 1'b1);
        queue_command(OP_LOAD, 1, Q_ONE, Q_MAX, 1'b0);
        queue_command(OP_QUERY, 0, 32'sh0, 32'sh0, 1'b0);
        queue_command(OP_QUERY, 0, Q_MAX, 32'sh0, 1'b0);
        queue_command(OP_QUERY, 0, Q_MIN, 32'sh0, 1'b1);
        // Zero-width segment, inside and outside the range.
        queue_command(OP_LOAD, 1, -Q_ONE, Q_MAX, 1'b0);
        queue_command(OP_QUERY, 0, 32'sh0, 32'sh0, 1'b0);
        queue_command(OP_QUERY, 0, -32'sh5_0000, 32'sh0, 1'b1);
        queue_command(OP_QUERY, 0, -Q_ONE, 32'sh0, 1'b0);
        // Unsorted table: x descends, so the slope divides by a negative width.
        queue_command(OP_LOAD, 0, 32'sh5_0000, 32'sh3_0000, 1'b0);
        queue_command(OP_LOAD, 1, -32'sh5_0000, -32'sh7_0000, 1'b0);
        queue_command(OP_QUERY, 0, 32'sh0, 32'sh0, 1'b0);
        queue_command(OP_QUERY, 0, 32'sh7_0000, 32'sh0, 1'b1);
        // Top table index with extreme values; not read at this count.
        queue_command(OP_LOAD, MAX_POINTS - 1, Q_MAX, Q_MIN, 1'b1);
        wait_until_idle();

        // Random phases: new count, fresh sorted table, then queries.
        phase = 0;
        while (command_total < ITEM_TARGET) begin
            write_point_count(phase < 7 ? counts[phase] : COUNT_W'($urandom_range(0, 127)));
            n = int'(point_count_model);
            if (n < 2) n = 2;
            if (n > MAX_POINTS) n = MAX_POINTS;
            steady_feed = (phase == 1);
            load_sorted_table(n);
            queries = $urandom_range(40, 80);
            for (int i = 0; i < queries; i++) begin
                pick = $urandom_range(0, 99);
                seg  = $urandom_range(0, n - 2);
                if (pick < 5) begin
                    // Stray load that may break the ordering of the table.
                    queue_command(OP_LOAD, $urandom_range(0, MAX_POINTS - 1), $signed($urandom),
                                  $signed($urandom), 1'($urandom_range(0, 1)));
                    continue;
                end else if (pick < 15) begin
                    xq = $signed($urandom);
                end else if (pick < 25) begin
                    xq = DATA_W'(gen_x[$urandom_range(0, n - 1)]);
                end else if (pick < 28) begin
                    xq = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
                end else begin
                    lo = gen_x[seg];
                    hi = gen_x[seg + 1];
                    xq = DATA_W'(lo + (longint'($urandom) % (hi - lo + 1)));
                end
                queue_command(OP_QUERY, $urandom_range(0, MAX_POINTS - 1), xq,
                              $signed($urandom), 1'($urandom_range(0, 1)));
            end
            wait_until_idle();
            phase++;
        end

        // Let any stray result show up before the verdict.
        steady_feed = 1'b0;
        repeat (END_DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
        end
        if (failure_count == 0) begin
            $display("** piecewise_linear_interpolator: PASSED **");
        end else begin
            $display("** piecewise_linear_interpolator: FAILED **");
        end
        $finish;
    end

endmodule
